// ----- rtl/pdra_pkg.sv -----
// ----------------------------------------------------------------------------
// pdra_pkg
// Shared types, constants and the CORDIC arctangent table for the polar disc
// remap address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pdra_pkg;

    localparam int MAX_RADIUS  = 2048;
    localparam int ANGLE_BITS  = 16;
    localparam int CORDIC_MAX  = 24;
    localparam int STEPS       = (ANGLE_BITS > CORDIC_MAX) ? CORDIC_MAX : ANGLE_BITS;
    // Coordinates: |d| <= 4095, prescaled by 256, CORDIC gain below 1.65.
    localparam int CW          = 24;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DISC_RADIUS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = 8'd1;

    typedef struct packed {
        logic [11:0] disc_x;
        logic [11:0] disc_y;
    } in_item_t;

    typedef struct packed {
        logic        inside_res;
        logic [12:0] source_col;
        logic [10:0] source_row;
    } out_item_t;

    typedef struct packed {
        logic        valid;
        logic        in_disc;
        logic        centre;
        logic [11:0] radius;
        logic [13:0] width;
        logic [24:0] d2;
    } side_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
            3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
            6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
            9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
            12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
            15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
            18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
            21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/polar_disc_remap_address.sv -----
// Throughput: one transfer per cycle while the result side does not stall.
// The CORDIC and square root are fully pipelined.
// A stall on the result side freezes the whole pipeline; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and restores R = 512, W = 2048.
// ----------------------------------------------------------------------------
// polar_disc_remap_address
// Maps an output disc pixel to a source column (angle) and row (distance).
// ----------------------------------------------------------------------------
`default_nettype none

module polar_disc_remap_address (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire pdra_pkg::in_item_t      s_data,
    output logic                         m_valid,
    input  wire                          m_ready,
    output pdra_pkg::out_item_t          m_data,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [pdra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [pdra_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pdra_pkg::*;

    logic [11:0] radius_reg;
    logic [13:0] width_reg;
    logic        en;

    side_t       s1_reg;
    logic signed [12:0] dx_reg, dy_reg;
    logic [23:0] dx2_reg, dy2_reg, r2_reg;
    side_t       s2_reg;

    side_t       c_side;
    logic [31:0] c_acc;
    logic [12:0] c_root;

    side_t       s3_reg;
    logic [ANGLE_BITS-1:0] frac_reg;
    logic [12:0] root3_reg;
    logic [ANGLE_BITS+13:0] prod_reg;
    side_t       s4_reg;
    logic [12:0] root4_reg;

    logic        out_valid_reg;
    out_item_t   out_reg;

    out_item_t   out_next;
    logic [13:0] col, wm1;
    logic [12:0] rfull, row;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid_reg || m_ready;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 12'd512;
            width_reg  <= 14'd2048;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DISC_RADIUS:  radius_reg <= cfg_data[11:0];
                REG_SOURCE_WIDTH: width_reg  <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // Stage 1: differences. Stage 2: squares.
    logic [12:0] r_sat;
    assign r_sat = ({1'b0, radius_reg} > 13'(MAX_RADIUS)) ? 13'(MAX_RADIUS)
                                                          : {1'b0, radius_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
        end else if (en) begin
            s1_reg.valid <= s_valid;
            s2_reg.valid <= s1_reg.valid;
        end
        if (en) begin
            dx_reg         <= $signed(r_sat) - $signed({1'b0, s_data.disc_x});
            dy_reg         <= $signed(r_sat) - $signed({1'b0, s_data.disc_y});
            s1_reg.radius  <= r_sat[11:0] | {11'd0, r_sat[12]};
            s1_reg.width   <= width_reg;
            s1_reg.in_disc <= 1'b0;
            s1_reg.centre  <= 1'b0;
            s1_reg.d2      <= {12'd0, r_sat};
            dx2_reg <= 24'(dx_reg * dx_reg);
            dy2_reg <= 24'(dy_reg * dy_reg);
            r2_reg  <= 24'({12'd0, s1_reg.d2[12:0]} * {12'd0, s1_reg.d2[12:0]});
            s2_reg.radius  <= s1_reg.d2[11:0];
            s2_reg.width   <= s1_reg.width;
            s2_reg.centre  <= (dx_reg == 13'sd0) && (dy_reg == 13'sd0);
            s2_reg.in_disc <= 1'b0;
            s2_reg.d2      <= '0;
        end
    end

    // dx/dy must accompany stage 2; hold a copy.
    logic signed [12:0] dx2d_reg, dy2d_reg;
    logic [12:0] rad2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            dx2d_reg <= dx_reg;
            dy2d_reg <= dy_reg;
            rad2_reg <= s1_reg.d2[12:0];
        end
    end

    side_t c_in;
    logic [24:0] d2_sum;
    logic [24:0] r2_full;
    assign d2_sum  = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign r2_full = {1'b0, r2_reg};
    always_comb begin
        c_in         = s2_reg;
        c_in.d2      = d2_sum;
        c_in.in_disc = d2_sum <= r2_full;
        c_in.radius  = rad2_reg[11:0];
    end

    pdra_cordic u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s2_reg.valid),
        .in_dx    (dx2d_reg),
        .in_dy    (dy2d_reg),
        .in_side  (c_in),
        .out_side (c_side),
        .out_acc  (c_acc),
        .out_root (c_root)
    );

    logic [31:0] ang;
    logic [32:0] rnd;
    assign ang = 32'h4000_0000 - c_acc;
    assign rnd = {1'b0, ang} + 33'(33'd1 << (31 - ANGLE_BITS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_reg.valid  <= 1'b0;
            s4_reg.valid  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            s3_reg.valid  <= c_side.valid;
            s4_reg.valid  <= s3_reg.valid;
            out_valid_reg <= s4_reg.valid;
        end
        if (en) begin
            s3_reg.in_disc <= c_side.in_disc;
            s3_reg.centre  <= c_side.centre;
            s3_reg.radius  <= c_side.radius;
            s3_reg.width   <= c_side.width;
            s3_reg.d2      <= c_side.d2;
            frac_reg       <= rnd[31:32-ANGLE_BITS];
            root3_reg      <= c_root;
            prod_reg       <= {14'd0, frac_reg} * {{ANGLE_BITS{1'b0}}, s3_reg.width};
            s4_reg.in_disc <= s3_reg.in_disc;
            s4_reg.centre  <= s3_reg.centre;
            s4_reg.radius  <= s3_reg.radius;
            s4_reg.width   <= s3_reg.width;
            s4_reg.d2      <= s3_reg.d2;
            root4_reg      <= root3_reg;
            out_reg        <= out_next;
        end
    end

    always_comb begin
        rfull = {1'b0, s4_reg.radius};
        wm1   = s4_reg.width - 14'd1;
        col   = prod_reg[ANGLE_BITS+13:ANGLE_BITS];
        if (s4_reg.width == 14'd0) begin
            col = 14'd0;
        end else if (col > wm1) begin
            col = wm1;
        end
        if (col > 14'd8191) begin
            col = 14'd8191;
        end
        row = root4_reg;
        if (row >= rfull) begin
            row = (rfull != 13'd0) ? rfull - 13'd1 : 13'd0;
        end
        if (row > 13'd2047) begin
            row = 13'd2047;
        end
        out_next.inside_res = s4_reg.in_disc;
        out_next.source_col = s4_reg.in_disc ? col[12:0] : 13'd0;
        out_next.source_row = s4_reg.in_disc ? row[10:0] : 11'd0;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.inside_res |-> m_data.source_col == 13'd0)
        else $error("outside pixel with nonzero column");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.inside_res |-> m_data.source_row == 11'd0)
        else $error("outside pixel with nonzero row");

endmodule

`default_nettype wire

// ----- rtl/pdra_cordic.sv -----
// ----------------------------------------------------------------------------
// pdra_cordic
// Pipelined vectoring CORDIC, one micro-rotation per register stage, with a
// square root alongside that resolves two result bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pdra_cordic (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    en,
    input  wire                    in_valid,
    input  wire signed [12:0]      in_dx,
    input  wire signed [12:0]      in_dy,
    input  wire pdra_pkg::side_t   in_side,
    output pdra_pkg::side_t        out_side,
    output logic [31:0]            out_acc,
    output logic [12:0]            out_root
);
    import pdra_pkg::*;

    localparam int N = STEPS;
    // Square root of a 25-bit value needs 13 two-bit steps; done two per stage in the leading stages.
    localparam int SQ = 13;

    logic signed [CW-1:0] x_reg   [N+1];
    logic signed [CW-1:0] y_reg   [N+1];
    logic [31:0]          acc_reg [N+1];
    side_t                side_reg[N+1];
    logic [25:0]          rem_reg [N+1];
    logic [12:0]          root_reg[N+1];
    logic [25:0]          dq_reg  [N+1];

    always_comb begin
        x_reg[0]    = CW'(in_dx) <<< 8;
        y_reg[0]    = CW'(in_dy) <<< 8;
        acc_reg[0]  = 32'd0;
        if (in_dx < 0) begin
            x_reg[0]   = -(CW'(in_dx) <<< 8);
            y_reg[0]   = -(CW'(in_dy) <<< 8);
            acc_reg[0] = 32'h8000_0000;
        end
        side_reg[0]       = in_side;
        side_reg[0].valid = in_valid;
        rem_reg[0]        = '0;
        root_reg[0]       = '0;
        dq_reg[0]         = {1'b0, in_side.d2};
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [CW-1:0] xs, ys, xn, yn;
        logic [31:0]          an;
        logic [25:0]          trial, rn, dn;
        logic [12:0]          qn;
        always_comb begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            if (y_reg[i] > 0) begin
                xn = x_reg[i] + ys;
                yn = y_reg[i] - xs;
                an = acc_reg[i] + atan_turn(i);
            end else begin
                xn = x_reg[i] - ys;
                yn = y_reg[i] + xs;
                an = acc_reg[i] - atan_turn(i);
            end
            rn    = rem_reg[i];
            dn    = dq_reg[i];
            qn    = root_reg[i];
            trial = '0;
            // Restoring square root: two result bits per stage.
            for (int j = 0; j < 2; j++) begin
                if (2 * i + j < SQ) begin
                    rn    = {rn[23:0], dn[25:24]};
                    dn    = {dn[23:0], 2'b00};
                    trial = {11'd0, qn, 2'b01};
                    if (rn >= trial) begin
                        rn = rn - trial;
                        qn = {qn[11:0], 1'b1};
                    end else begin
                        qn = {qn[11:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[i+1].valid <= 1'b0;
            end else if (en) begin
                side_reg[i+1].valid <= side_reg[i].valid;
            end
            if (en) begin
                x_reg[i+1]    <= xn;
                y_reg[i+1]    <= yn;
                acc_reg[i+1]  <= an;
                rem_reg[i+1]  <= rn;
                root_reg[i+1] <= qn;
                dq_reg[i+1]   <= dn;
                side_reg[i+1].in_disc <= side_reg[i].in_disc;
                side_reg[i+1].centre  <= side_reg[i].centre;
                side_reg[i+1].radius  <= side_reg[i].radius;
                side_reg[i+1].width   <= side_reg[i].width;
                side_reg[i+1].d2      <= side_reg[i].d2;
            end
        end
    end

    assign out_side = side_reg[N];
    assign out_acc  = side_reg[N].centre ? 32'd0 : acc_reg[N];
    assign out_root = root_reg[N];

endmodule

`default_nettype wire
